// ----- hw/rtl/hgl_pkg.sv -----
// hgl_pkg: shared types and constants for the histogram to gain table block
// no dependencies; imported by histogram_to_gain_lut

package hgl_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_POWER_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_UNITY_GAIN      = 3'd1;
    localparam logic [2:0] CFG_MAX_GAIN        = 3'd2;
    localparam logic [2:0] CFG_MIN_SLOPE       = 3'd3;
    localparam logic [2:0] CFG_MAX_SLOPE       = 3'd4;

    // register reset values
    localparam logic [15:0] RST_POWER_THRESHOLD = 16'd62259;
    localparam logic [12:0] RST_UNITY_GAIN      = 13'd512;
    localparam logic [15:0] RST_MAX_GAIN        = 16'd4095;
    localparam logic [11:0] RST_MIN_SLOPE       = 12'd77;
    localparam logic [11:0] RST_MAX_SLOPE       = 12'd1792;

    // curve values are q0.16 with one extra bit so 1.0 fits
    localparam int CURVE_W = 17;
    localparam logic [CURVE_W-1:0] Q16_ONE = 17'h10000;

    // quotient bits of the shared divider
    localparam int QUO_W = 20;
    // width of the per-bin slope step
    localparam int STEP_W = 19;

    // reciprocal for the divide by three of the 3-tap average
    localparam int DIV3_IN_W = 18;
    localparam int DIV3_SH = 20;
    localparam logic [18:0] DIV3_RECIP = 19'd349526;

    // 32-point srgb decode table, q0.16
    localparam logic [15:0] SRGB_TABLE [32] = '{
        16'd0,     16'd164,   16'd352,   16'd625,   16'd992,   16'd1461,  16'd2040,  16'd2734,
        16'd3550,  16'd4492,  16'd5565,  16'd6776,  16'd8127,  16'd9623,  16'd11269, 16'd13069,
        16'd15026, 16'd17144, 16'd19426, 16'd21877, 16'd24499, 16'd27296, 16'd30271, 16'd33426,
        16'd36766, 16'd40293, 16'd44009, 16'd47919, 16'd52023, 16'd56326, 16'd60829, 16'd65535
    };

    // sequencer states
    typedef enum logic [4:0] {
        ST_LOAD,
        ST_P1_RD,
        ST_P1_MUL,
        ST_P1_ACC,
        ST_LIM0,
        ST_LIM1,
        ST_P2_RD,
        ST_P2_MUL,
        ST_P2_CMP,
        ST_DECIDE,
        ST_SLOPE0,
        ST_SLOPE1,
        ST_CV_RD,
        ST_CV_ACC,
        ST_CV_DSTART,
        ST_CV_DIV,
        ST_CV_UPD,
        ST_CV_SM,
        ST_CV_LAST,
        ST_G_RD0,
        ST_G_RD1,
        ST_G_MUL,
        ST_G_NUM,
        ST_G_UMUL,
        ST_G_DSTART,
        ST_G_DIV,
        ST_G_CLAMP,
        ST_EMIT
    } hgl_state_t;

endpackage

// ----- hw/rtl/hgl_ram.sv -----
// hgl_ram: generic single write, single read ram with registered read data
// no dependencies

module hgl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/histogram_to_gain_lut.sv -----
// histogram_to_gain_lut: contrast limited equalization gain table from a histogram
// depends on hgl_pkg and hgl_ram

// Bins are taken one per cycle into a bin ram while s_ready is high. The
// transaction that carries s_last_bin starts the table computation, and
// s_ready stays low until the last table entry has been taken. The
// computation walks the bin ram twice (frame power, then the solid test),
// then for a non-solid frame once more, dominated by the shared divider
// that normalizes the cumulative curve. Each gain entry then takes two
// curve ram reads, the products and the same divider, plus the output
// handshake; entry 0 carries the gain of entry 1, and entry 1 is shown once
// entry 0 has been taken. Configuration writes are taken at any time and
// must only be issued while the block is idle.

module histogram_to_gain_lut #(
    parameter int BINS        = 32,
    parameter int LUT_ENTRIES = 33,
    parameter int COUNT_BITS  = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // bin input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COUNT_BITS-1:0] s_bin_count,
    input  logic                  s_last_bin,
    // gain table output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [5:0]            m_entry_index,
    output logic [15:0]           m_gain,
    output logic                  m_solid_frame,
    output logic                  m_last_entry,
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    import hgl_pkg::*;

    localparam int AW   = $clog2(BINS);
    localparam int PTRW = $clog2(BINS + 1);
    localparam int CW   = COUNT_BITS + AW;
    localparam int PW   = COUNT_BITS + 8;
    localparam int TW   = PW + AW;
    localparam int LW   = TW + 16;
    localparam int JW   = $clog2(LUT_ENTRIES);
    localparam int NW   = CURVE_W + JW;
    localparam int GDW  = NW + 14;
    localparam int DDW  = (CW + 17 > GDW) ? CW + 17 : GDW;
    localparam int DVW  = (CW > 16 + JW) ? CW : 16 + JW;
    localparam int CNTW = $clog2(QUO_W + 1);

    // slope step divide by bins-1 as a reciprocal multiply
    localparam int SL_L  = $clog2(BINS - 1);
    localparam int SL_SH = 20 + SL_L;
    localparam longint SL_RECIP_L =
        ((longint'(1) << SL_SH) + longint'(BINS - 1) - 1) / longint'(BINS - 1);
    localparam logic [20:0] SL_RECIP = 21'(SL_RECIP_L);
    localparam logic [19:0] SL_HALF = 20'((BINS - 1) / 2);

    // interpolation step per table entry
    localparam int QSTEP = (BINS - 1) / (LUT_ENTRIES - 1);
    localparam int RSTEP = (BINS - 1) % (LUT_ENTRIES - 1);
    localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);
    localparam logic [JW-1:0] LAST_J = JW'(LUT_ENTRIES - 1);

    // linear weight rom, interpolated from the 32-point table
    logic [15:0] rom_w [BINS];
    for (genvar gi = 0; gi < BINS; gi++) begin : g_rom
        localparam int P  = gi * 31;
        localparam int Q  = P / (BINS - 1);
        localparam int R  = P % (BINS - 1);
        localparam int LO = int'(SRGB_TABLE[(Q >= 31) ? 31 : Q]);
        localparam int HI = int'(SRGB_TABLE[(Q >= 30) ? 31 : Q + 1]);
        localparam int V  = (Q >= 31) ? 65535 :
                            (R == 0) ? LO : LO + ((HI - LO) * R + (BINS - 1) / 2) / (BINS - 1);
        assign rom_w[gi] = 16'(V);
    end

    // registers
    hgl_state_t state_reg, state_next;
    logic [15:0] thr_reg;
    logic [12:0] unity_reg;
    logic [15:0] maxg_reg;
    logic [11:0] mins_reg, maxs_reg;
    logic [PTRW-1:0] bin_ptr_reg, bin_ptr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0] h0_reg, h0_next;
    logic [TW-1:0] total_reg, total_next;
    logic [PW-1:0] power_reg, power_next;
    logic [PW-1:0] prevp_reg, prevp_next;
    logic [LW-1:0] limit_reg, limit_next;
    logic [CW-1:0] range_reg, range_next;
    logic solid_reg, solid_next;
    logic [STEP_W-1:0] dmin_reg, dmin_next, dmax_reg, dmax_next;
    logic [CW-1:0] numacc_reg, numacc_next;
    logic [CURVE_W-1:0] ea_reg, ea_next, eb_reg, eb_next;
    logic [DIV3_IN_W-1:0] sum3_reg, sum3_next;
    logic [DVW:0] div_rem_reg, div_rem_next;
    logic [QUO_W-1:0] div_q_reg, div_q_next;
    logic [DVW-1:0] div_dvs_reg, div_dvs_next;
    logic [CNTW-1:0] div_cnt_reg, div_cnt_next;
    logic [JW-1:0] j_reg, j_next;
    logic [AW-1:0] q_reg, q_next;
    logic [JW-1:0] r_reg, r_next;
    logic [CURVE_W-1:0] fq_reg, fq_next;
    logic [NW-1:0] a_reg, a_next;
    logic signed [NW:0] b_reg, b_next;
    logic [NW-1:0] num_reg, num_next;
    logic [DDW-1:0] gdiv_reg, gdiv_next;
    logic [JW-1:0] out_idx_reg, out_idx_next;
    logic [15:0] out_gain_reg, out_gain_next;

    // memory ports
    logic bin_we;
    logic [COUNT_BITS-1:0] bin_rdata;
    logic crv_we;
    logic [AW-1:0] crv_waddr, crv_raddr;
    logic [CURVE_W-1:0] crv_wdata, crv_rdata;

    hgl_ram #(.WIDTH(COUNT_BITS), .DEPTH(BINS)) u_bin_ram (
        .aclk  (aclk),
        .we    (bin_we),
        .waddr (bin_ptr_reg[AW-1:0]),
        .wdata (s_bin_count),
        .raddr (idx_reg),
        .rdata (bin_rdata)
    );

    hgl_ram #(.WIDTH(CURVE_W), .DEPTH(BINS)) u_curve_ram (
        .aclk  (aclk),
        .we    (crv_we),
        .waddr (crv_waddr),
        .wdata (crv_wdata),
        .raddr (crv_raddr),
        .rdata (crv_rdata)
    );

    // handshakes
    assign s_ready   = (state_reg == ST_LOAD);
    assign m_valid   = (state_reg == ST_EMIT);
    assign cfg_ready = 1'b1;
    assign bin_we    = s_valid && s_ready && (bin_ptr_reg < PTRW'(BINS));

    assign m_entry_index = 6'(out_idx_reg);
    assign m_gain        = out_gain_reg;
    assign m_solid_frame = solid_reg;
    assign m_last_entry  = (out_idx_reg == LAST_J);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg   <= RST_POWER_THRESHOLD;
            unity_reg <= RST_UNITY_GAIN;
            maxg_reg  <= RST_MAX_GAIN;
            mins_reg  <= RST_MIN_SLOPE;
            maxs_reg  <= RST_MAX_SLOPE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_POWER_THRESHOLD: thr_reg   <= cfg_data;
                CFG_UNITY_GAIN:      unity_reg <= cfg_data[12:0];
                CFG_MAX_GAIN:        maxg_reg  <= cfg_data;
                CFG_MIN_SLOPE:       mins_reg  <= cfg_data[11:0];
                CFG_MAX_SLOPE:       maxs_reg  <= cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            bin_ptr_reg <= '0;
        end else begin
            state_reg   <= state_next;
            bin_ptr_reg <= bin_ptr_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        acc_reg      <= acc_next;
        h0_reg       <= h0_next;
        total_reg    <= total_next;
        power_reg    <= power_next;
        prevp_reg    <= prevp_next;
        limit_reg    <= limit_next;
        range_reg    <= range_next;
        solid_reg    <= solid_next;
        dmin_reg     <= dmin_next;
        dmax_reg     <= dmax_next;
        numacc_reg   <= numacc_next;
        ea_reg       <= ea_next;
        eb_reg       <= eb_next;
        sum3_reg     <= sum3_next;
        div_rem_reg  <= div_rem_next;
        div_q_reg    <= div_q_next;
        div_dvs_reg  <= div_dvs_next;
        div_cnt_reg  <= div_cnt_next;
        j_reg        <= j_next;
        q_reg        <= q_next;
        r_reg        <= r_next;
        fq_reg       <= fq_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        num_reg      <= num_next;
        gdiv_reg     <= gdiv_next;
        out_idx_reg  <= out_idx_next;
        out_gain_reg <= out_gain_next;
    end

    // sequencer and datapath
    always_comb begin
        logic [COUNT_BITS+15:0] wprod;
        logic [47:0] total_ext;
        logic [PW:0] pair_sum;
        logic [19:0] sl_x;
        logic [40:0] sl_prod;
        logic [DVW:0] div_t;
        logic signed [20:0] d_s;
        logic signed [20:0] dmin_s, dmax_s;
        logic [20:0] nv;
        logic [CURVE_W-1:0] e_new;
        logic [36:0] f_prod;
        logic signed [NW+1:0] num_s;
        logic [JW:0] r_sum;
        logic [15:0] g_lim;

        state_next    = state_reg;
        bin_ptr_next  = bin_ptr_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        h0_next       = h0_reg;
        total_next    = total_reg;
        power_next    = power_reg;
        prevp_next    = prevp_reg;
        limit_next    = limit_reg;
        range_next    = range_reg;
        solid_next    = solid_reg;
        dmin_next     = dmin_reg;
        dmax_next     = dmax_reg;
        numacc_next   = numacc_reg;
        ea_next       = ea_reg;
        eb_next       = eb_reg;
        sum3_next     = sum3_reg;
        div_rem_next  = div_rem_reg;
        div_q_next    = div_q_reg;
        div_dvs_next  = div_dvs_reg;
        div_cnt_next  = div_cnt_reg;
        j_next        = j_reg;
        q_next        = q_reg;
        r_next        = r_reg;
        fq_next       = fq_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        num_next      = num_reg;
        gdiv_next     = gdiv_reg;
        out_idx_next  = out_idx_reg;
        out_gain_next = out_gain_reg;
        crv_we        = 1'b0;
        crv_waddr     = '0;
        crv_wdata     = '0;
        crv_raddr     = q_reg;

        // shared helpers
        wprod     = bin_rdata * rom_w[idx_reg];
        total_ext = 48'(total_reg);
        pair_sum  = {1'b0, prevp_reg} + {1'b0, power_reg};
        sl_x      = '0;
        sl_prod   = '0;
        div_t     = {div_rem_reg[DVW-1:0], div_q_reg[QUO_W-1]};
        dmin_s    = $signed({2'b00, dmin_reg});
        dmax_s    = $signed({2'b00, dmax_reg});
        d_s       = $signed({4'b0000, div_q_reg[CURVE_W-1:0]}) - $signed({4'b0000, eb_reg});
        nv        = '0;
        e_new     = '0;
        f_prod    = sum3_reg * DIV3_RECIP;
        num_s     = $signed({2'b00, a_reg}) + (NW+2)'(b_reg);
        r_sum     = {1'b0, r_reg} + (JW+1)'(RSTEP);
        g_lim     = (div_q_reg > QUO_W'(maxg_reg)) ? maxg_reg : div_q_reg[15:0];

        unique case (state_reg)
            // take bins into the bin ram
            ST_LOAD: begin
                if (s_valid) begin
                    if (bin_ptr_reg < PTRW'(BINS)) begin
                        bin_ptr_next = bin_ptr_reg + 1'b1;
                    end
                    if (s_last_bin) begin
                        bin_ptr_next = '0;
                        idx_next     = '0;
                        acc_next     = '0;
                        total_next   = '0;
                        state_next   = ST_P1_RD;
                    end
                end
            end
            // first pass: cumulative count and frame power
            ST_P1_RD: begin
                state_next = ST_P1_MUL;
            end
            ST_P1_MUL: begin
                power_next = PW'(wprod >> 8);
                acc_next   = acc_reg + CW'(bin_rdata);
                if (idx_reg == '0) begin
                    h0_next = bin_rdata;
                end
                state_next = ST_P1_ACC;
            end
            ST_P1_ACC: begin
                total_next = total_reg + TW'(power_reg);
                if (idx_reg == LAST_BIN) begin
                    state_next = ST_LIM0;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_P1_RD;
                end
            end
            // solid threshold in two partial products
            ST_LIM0: begin
                limit_next = LW'(thr_reg * total_ext[23:0]);
                state_next = ST_LIM1;
            end
            ST_LIM1: begin
                limit_next = limit_reg + (LW'(thr_reg * total_ext[47:24]) << 24);
                range_next = acc_reg - CW'(h0_reg);
                solid_next = 1'b0;
                idx_next   = '0;
                state_next = ST_P2_RD;
            end
            // second pass: single bin and adjacent pair test
            ST_P2_RD: begin
                state_next = ST_P2_MUL;
            end
            ST_P2_MUL: begin
                power_next = PW'(wprod >> 8);
                state_next = ST_P2_CMP;
            end
            ST_P2_CMP: begin
                if (LW'({power_reg, 16'h0}) >= limit_reg) begin
                    solid_next = 1'b1;
                end
                if (idx_reg != '0 && LW'({pair_sum, 16'h0}) >= limit_reg) begin
                    solid_next = 1'b1;
                end
                prevp_next = power_reg;
                if (idx_reg == LAST_BIN) begin
                    state_next = ST_DECIDE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_P2_RD;
                end
            end
            ST_DECIDE: begin
                if (solid_reg || range_reg == '0) begin
                    solid_next    = 1'b1;
                    out_idx_next  = '0;
                    out_gain_next = 16'(unity_reg);
                    state_next    = ST_EMIT;
                end else begin
                    state_next = ST_SLOPE0;
                end
            end
            // slope clamps, curve start point
            ST_SLOPE0: begin
                sl_x       = {mins_reg, 8'h00} + SL_HALF;
                sl_prod    = sl_x * SL_RECIP;
                dmin_next  = STEP_W'(sl_prod >> SL_SH);
                crv_we     = 1'b1;
                crv_waddr  = '0;
                crv_wdata  = '0;
                state_next = ST_SLOPE1;
            end
            ST_SLOPE1: begin
                sl_x        = {maxs_reg, 8'h00} + SL_HALF;
                sl_prod     = sl_x * SL_RECIP;
                dmax_next   = STEP_W'(sl_prod >> SL_SH);
                numacc_next = '0;
                ea_next     = '0;
                eb_next     = '0;
                idx_next    = AW'(1);
                state_next  = ST_CV_RD;
            end
            // curve pass: normalize, clamp slope, smooth
            ST_CV_RD: begin
                state_next = ST_CV_ACC;
            end
            ST_CV_ACC: begin
                numacc_next = numacc_reg + CW'(bin_rdata);
                state_next  = ST_CV_DSTART;
            end
            ST_CV_DSTART: begin
                gdiv_next    = DDW'({numacc_reg, 16'h0}) + DDW'(range_reg >> 1);
                div_rem_next = (DVW+1)'(gdiv_next >> QUO_W);
                div_q_next   = gdiv_next[QUO_W-1:0];
                div_dvs_next = DVW'(range_reg);
                div_cnt_next = CNTW'(QUO_W);
                state_next   = ST_CV_DIV;
            end
            ST_CV_DIV, ST_G_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = (state_reg == ST_CV_DIV) ? ST_CV_UPD : ST_G_CLAMP;
                end else begin
                    if (div_t >= {1'b0, div_dvs_reg}) begin
                        div_rem_next = div_t - {1'b0, div_dvs_reg};
                        div_q_next   = {div_q_reg[QUO_W-2:0], 1'b1};
                    end else begin
                        div_rem_next = div_t;
                        div_q_next   = {div_q_reg[QUO_W-2:0], 1'b0};
                    end
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end
            ST_CV_UPD: begin
                if (d_s < dmin_s) begin
                    d_s = dmin_s;
                end
                if (d_s > dmax_s) begin
                    d_s = dmax_s;
                end
                nv = {4'b0000, eb_reg} + 21'(d_s);
                if (nv > 21'(Q16_ONE)) begin
                    nv = 21'(Q16_ONE);
                end
                e_new     = nv[CURVE_W-1:0];
                sum3_next = DIV3_IN_W'(ea_reg) + DIV3_IN_W'(eb_reg) + DIV3_IN_W'(e_new) + 1'b1;
                ea_next   = eb_reg;
                eb_next   = e_new;
                if (idx_reg == AW'(1)) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CV_RD;
                end else begin
                    state_next = ST_CV_SM;
                end
            end
            ST_CV_SM: begin
                crv_we    = 1'b1;
                crv_waddr = idx_reg - 1'b1;
                crv_wdata = CURVE_W'(f_prod >> DIV3_SH);
                if (idx_reg == LAST_BIN) begin
                    state_next = ST_CV_LAST;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_CV_RD;
                end
            end
            ST_CV_LAST: begin
                crv_we     = 1'b1;
                crv_waddr  = LAST_BIN;
                crv_wdata  = eb_reg;
                j_next     = JW'(1);
                q_next     = AW'(QSTEP);
                r_next     = JW'(RSTEP);
                state_next = ST_G_RD0;
            end
            // gain entries: interpolate, scale, divide by level
            ST_G_RD0: begin
                crv_raddr  = q_reg;
                state_next = ST_G_RD1;
            end
            ST_G_RD1: begin
                fq_next    = crv_rdata;
                crv_raddr  = (q_reg == LAST_BIN) ? q_reg : q_reg + 1'b1;
                state_next = ST_G_MUL;
            end
            ST_G_MUL: begin
                a_next = NW'(fq_reg * LAST_J);
                b_next = (NW+1)'(($signed({1'b0, crv_rdata}) - $signed({1'b0, fq_reg}))
                         * $signed({1'b0, r_reg}));
                state_next = ST_G_NUM;
            end
            ST_G_NUM: begin
                num_next   = (num_s < 0) ? '0 : NW'(num_s);
                state_next = ST_G_UMUL;
            end
            ST_G_UMUL: begin
                gdiv_next  = DDW'(unity_reg * num_reg) + DDW'({j_reg, 15'h0});
                state_next = ST_G_DSTART;
            end
            ST_G_DSTART: begin
                div_rem_next = (DVW+1)'(gdiv_reg >> QUO_W);
                div_q_next   = gdiv_reg[QUO_W-1:0];
                div_dvs_next = DVW'({j_reg, 16'h0});
                div_cnt_next = CNTW'(QUO_W);
                state_next   = ST_G_DIV;
            end
            ST_G_CLAMP: begin
                out_gain_next = (g_lim < 16'(unity_reg)) ? 16'(unity_reg) : g_lim;
                out_idx_next  = (j_reg == JW'(1)) ? '0 : j_reg;
                state_next    = ST_EMIT;
            end
            // present one entry until its transaction completes
            ST_EMIT: begin
                if (m_ready) begin
                    if (out_idx_reg == LAST_J) begin
                        state_next = ST_LOAD;
                    end else if (solid_reg || out_idx_reg == '0) begin
                        out_idx_next = out_idx_reg + 1'b1;
                    end else begin
                        j_next = j_reg + 1'b1;
                        if (r_sum >= (JW+1)'(LUT_ENTRIES - 1)) begin
                            r_next = JW'(r_sum - (JW+1)'(LUT_ENTRIES - 1));
                            q_next = q_reg + AW'(QSTEP) + 1'b1;
                        end else begin
                            r_next = JW'(r_sum);
                            q_next = q_reg + AW'(QSTEP);
                        end
                        state_next = ST_G_RD0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

`ifndef SYNTHESIS
    // no bin is taken while a table is being delivered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while table entries pending");

    // the block is ready for a new histogram right after the final entry
    a_ready_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_entry) |=> s_ready)
        else $error("not ready after final table entry");

    // a table is never cut short
    a_no_early_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_entry) |=> !s_ready)
        else $error("table ended before its final entry");
`endif

endmodule

// ----- bench/tb_top.sv -----
// tb_top: self-checking bench for histogram_to_gain_lut, gain tables checked per frame
// depends on hgl_pkg and the histogram_to_gain_lut rtl

`timescale 1ns / 100ps

// expected gain table entries, filled per frame and consumed by the output monitor
class gain_table_scoreboard;
    typedef struct {
        logic [5:0]  entry_index;
        logic [15:0] gain;
        logic        solid_frame;
        logic        last_entry;
    } gain_entry_t;

    gain_entry_t pending_entries[$];
    int          error_count;

    // bins, configuration and weights held by the predictor
    logic [23:0] bin_counts[32];
    int          bin_fill;
    logic [15:0] weights[32];
    logic [15:0] power_threshold;
    logic [12:0] unity_gain;
    logic [15:0] max_gain;
    logic [11:0] min_slope;
    logic [11:0] max_slope;

    function new();
        foreach (weights[i]) weights[i] = hgl_pkg::SRGB_TABLE[i];
        foreach (bin_counts[i]) bin_counts[i] = '0;
        bin_fill        = 0;
        error_count     = 0;
        power_threshold = hgl_pkg::RST_POWER_THRESHOLD;
        unity_gain      = hgl_pkg::RST_UNITY_GAIN;
        max_gain        = hgl_pkg::RST_MAX_GAIN;
        min_slope       = hgl_pkg::RST_MIN_SLOPE;
        max_slope       = hgl_pkg::RST_MAX_SLOPE;
    endfunction

    function void note_config(logic [2:0] index, logic [15:0] data);
        case (index)
            hgl_pkg::CFG_POWER_THRESHOLD: power_threshold = data;
            hgl_pkg::CFG_UNITY_GAIN:      unity_gain      = data[12:0];
            hgl_pkg::CFG_MAX_GAIN:        max_gain        = data;
            hgl_pkg::CFG_MIN_SLOPE:       min_slope       = data[11:0];
            hgl_pkg::CFG_MAX_SLOPE:       max_slope       = data[11:0];
            default: ;
        endcase
    endfunction

    // store one bin; on the last bin compute the whole gain table
    function void note_bin(logic [23:0] count, logic last);
        longint unsigned power[32], cum[32], total, acc, limit, range_sum, num_u, g;
        longint          dmin, dmax, prev, target, delta, next, num;
        longint unsigned raw[32], smooth[32];
        longint unsigned gains[33];
        bit              solid;
        int              q, r;
        gain_entry_t     e;
        if (bin_fill < 32) begin
            bin_counts[bin_fill] = count;
            bin_fill++;
        end
        if (!last) return;
        bin_fill = 0;
        total = 0;
        acc = 0;
        solid = 0;
        for (int i = 0; i < 32; i++) begin
            acc += bin_counts[i];
            cum[i] = acc;
            power[i] = (longint'(bin_counts[i]) * weights[i]) >> 8;
            total += power[i];
        end
        limit = longint'(power_threshold) * total;
        for (int i = 0; i < 32; i++) begin
            if ((power[i] << 16) >= limit) solid = 1;
            if (i < 31 && ((power[i] + power[i+1]) << 16) >= limit) solid = 1;
        end
        range_sum = cum[31] - bin_counts[0];
        if (range_sum == 0) solid = 1;
        if (solid) begin
            foreach (gains[j]) gains[j] = unity_gain;
        end else begin
            dmin = (longint'(min_slope) * 256 + 15) / 31;
            dmax = (longint'(max_slope) * 256 + 15) / 31;
            prev = 0;
            raw[0] = 0;
            for (int i = 1; i < 32; i++) begin
                num_u = cum[i] - bin_counts[0];
                target = (num_u * 65536 + range_sum / 2) / range_sum;
                delta = target - prev;
                if (delta < dmin) delta = dmin;
                if (delta > dmax) delta = dmax;
                next = prev + delta;
                if (next > 65536) next = 65536;
                raw[i] = next;
                prev = next;
            end
            smooth[0] = raw[0];
            smooth[31] = raw[31];
            for (int i = 1; i < 31; i++) smooth[i] = (raw[i-1] + raw[i] + raw[i+1] + 1) / 3;
            for (int j = 1; j < 33; j++) begin
                q = (j * 31) / 32;
                r = (j * 31) % 32;
                num = longint'(smooth[q]) * 32;
                if (r != 0 && q < 31) num += (longint'(smooth[q+1]) - longint'(smooth[q])) * r;
                if (num < 0) num = 0;
                g = (longint'(unity_gain) * num + 32768 * j) / (65536 * j);
                if (g > max_gain) g = max_gain;
                if (g < unity_gain) g = unity_gain;
                gains[j] = g;
            end
            gains[0] = gains[1];
        end
        for (int j = 0; j < 33; j++) begin
            e.entry_index = 6'(j);
            e.gain        = gains[j][15:0];
            e.solid_frame = solid;
            e.last_entry  = (j == 32);
            pending_entries.push_back(e);
        end
    endfunction

    task report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task check_entry(logic [5:0] idx, logic [15:0] gain, logic solid, logic last);
        gain_entry_t e;
        if (pending_entries.size() == 0) begin
            report_mismatch("unexpected entry index", idx, -1);
            return;
        end
        e = pending_entries.pop_front();
        if (idx !== e.entry_index) report_mismatch("entry_index", idx, e.entry_index);
        if (gain !== e.gain) report_mismatch("gain", gain, e.gain);
        if (solid !== e.solid_frame) report_mismatch("solid_frame", solid, e.solid_frame);
        if (last !== e.last_entry) report_mismatch("last_entry", last, e.last_entry);
    endtask
endclass

module tb_top;
    import hgl_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [23:0] s_bin_count = '0;
    logic        s_last_bin = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [5:0]  m_entry_index;
    logic [15:0] m_gain;
    logic        m_solid_frame;
    logic        m_last_entry;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int sender_idle_pct;
    int receiver_idle_pct;
    int idle_cycles = 0;

    gain_table_scoreboard gain_sb;

    histogram_to_gain_lut DUT (.*);

    always #6 aclk = ~aclk;

    // output side: random stalls, checks each accepted entry
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            gain_sb.check_entry(m_entry_index, m_gain, m_solid_frame, m_last_entry);
        m_ready <= aresetn && ($urandom_range(99) >= receiver_idle_pct);
    end

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // valid stays high after the transaction; the caller drops it when no bin follows
    task send_bin(logic [23:0] count, logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid     <= 1;
        s_bin_count <= count;
        s_last_bin  <= last;
        do @(posedge aclk); while (!s_ready);
        gain_sb.note_bin(count, last);
    endtask

    // wait for table to drain plus computation slack before touching registers
    task wait_idle();
        s_valid <= 0;
        while (gain_sb.pending_entries.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // valid stays high after the transaction; set_all drops it after the last write
    task write_reg(logic [2:0] index, logic [15:0] data);
        cfg_valid <= 1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        gain_sb.note_config(index, data);
    endtask

    task set_all(logic [15:0] thr, logic [15:0] unity, logic [15:0] maxg,
                 logic [15:0] smin, logic [15:0] smax);
        wait_idle();
        write_reg(CFG_POWER_THRESHOLD, thr);
        write_reg(CFG_UNITY_GAIN, unity);
        write_reg(CFG_MAX_GAIN, maxg);
        write_reg(CFG_MIN_SLOPE, smin);
        write_reg(CFG_MAX_SLOPE, smax);
        cfg_valid <= 0;
    endtask

    // one full frame of random bins, with a chosen shape
    task send_frame(int shape);
        logic [23:0] c;
        int          peak;
        peak = $urandom_range(31);
        for (int i = 0; i < 32; i++) begin
            case (shape)
                0: c = 24'($urandom_range(4000));
                1: c = 24'($urandom);
                2: c = (i == peak) ? 24'($urandom_range(16777215, 1000000)) : 24'($urandom_range(50));
                default: c = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(300));
            endcase
            send_bin(c, i == 31);
        end
    endtask

    // frame with an early last bin after at least one full frame
    task send_short_frame();
        int n;
        n = $urandom_range(31, 1);
        for (int i = 0; i < n; i++) send_bin(24'($urandom_range(20000)), i == n - 1);
    endtask

    task run_random(int frames);
        int pick;
        for (int f = 0; f < frames; f++) begin
            pick = $urandom_range(9);
            if (pick < 7) send_frame(pick % 4);
            else if (pick == 7) send_short_frame();
            else begin
                // too many bins, the extras are dropped
                for (int i = 0; i < 34; i++) send_bin(24'($urandom), i == 33);
            end
        end
    endtask

    initial begin
        gain_sb = new();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, zero frame, all in bin 0, solid, spread, overlong and short frames
        for (int i = 0; i < 32; i++) send_bin(24'hFFFFFF, i == 31);
        for (int i = 0; i < 32; i++) send_bin(0, i == 31);
        for (int i = 0; i < 32; i++) send_bin(i == 0 ? 24'd5000 : 24'd0, i == 31);
        for (int i = 0; i < 32; i++) send_bin(i == 20 ? 24'd9000 : 24'd1, i == 31);
        for (int i = 0; i < 32; i++) send_bin((i == 10 || i == 11) ? 24'd800 : 24'd30, i == 31);
        for (int i = 0; i < 32; i++) send_bin(24'(100 + i * 37), i == 31);
        for (int i = 0; i < 34; i++) send_bin(24'(200 + i), i == 33);
        send_bin(24'hAAAAAA, 0);
        send_bin(24'h555555, 1);

        // extreme register settings, including inverted clamps
        set_all(16'd0, 16'd4096, 16'd65535, 16'd4095, 16'd4095);
        send_frame(0);
        set_all(16'd65535, 16'd1, 16'd1, 16'd0, 16'd0);
        send_frame(1);
        set_all(16'hFFFF, 16'hFFFF, 16'd300, 16'd4095, 16'd10);
        send_frame(3);
        set_all(RST_POWER_THRESHOLD, RST_UNITY_GAIN, RST_MAX_GAIN,
                RST_MIN_SLOPE, RST_MAX_SLOPE);

        // random phases with changing idling
        sender_idle_pct = 14;
        receiver_idle_pct = 56;
        run_random(1);
        set_all(16'($urandom), 16'($urandom_range(4096, 1)), 16'($urandom), 16'($urandom),
                16'($urandom));
        sender_idle_pct = 56;
        receiver_idle_pct = 14;
        run_random(1);
        set_all(16'd50000, 16'($urandom_range(1024, 64)), 16'd8191, 16'($urandom_range(200)),
                16'($urandom_range(4095, 1000)));
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        run_random(1);

        s_valid <= 0;
        while (gain_sb.pending_entries.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (gain_sb.error_count == 0 && gain_sb.pending_entries.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
